// File: src/i2cps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cps_pkg
// shared types and constants for the i2c master phase sequencer
// ----------------------------------------------------------------------------
package i2cps_pkg;

    localparam int OP_W        = 3;
    localparam int DATA_W      = 8;
    localparam int PHASE_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_WAIT  = 3'd4;

    localparam logic [PHASE_W-1:0] WR_CLK_LOW_PHASE = 5'd24;
    localparam logic [PHASE_W-1:0] WR_LAST_PHASE    = 5'd25;
    localparam logic [PHASE_W-1:0] RD_LAST_PHASE    = 5'd18;

    localparam logic [1:0] SUB_CLK_LOW = 2'd0;
    localparam logic [1:0] SUB_DATA    = 2'd1;
    localparam logic [1:0] SUB_CLK_HIGH = 2'd2;

    // classified request: data is the write byte or the sampled line bits
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

// File: src/i2cps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cps_front
// accepts requests, drops unknown operations, picks the byte the run needs
// ----------------------------------------------------------------------------
module i2cps_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [i2cps_pkg::OP_W-1:0]     s_operation,
    input  logic [i2cps_pkg::DATA_W-1:0]   s_write_data,
    input  logic [i2cps_pkg::DATA_W-1:0]   s_line_bits,
    output logic                           push_valid,
    input  logic                           push_ready,
    output i2cps_pkg::cmd_t                push_cmd
);
    import i2cps_pkg::*;

    logic front_valid_reg;
    cmd_t front_cmd_reg;
    cmd_t front_cmd_next;
    logic op_known;

    assign s_ready    = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_cmd   = front_cmd_reg;

    always_comb begin
        op_known = 1'b0;
        front_cmd_next.op   = s_operation;
        front_cmd_next.data = s_write_data;
        unique case (s_operation)
            OP_START, OP_STOP, OP_WRITE, OP_WAIT: begin
                op_known = 1'b1;
            end
            OP_READ: begin
                op_known = 1'b1;
                front_cmd_next.data = s_line_bits;
            end
            default: begin
                op_known = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid && op_known;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            front_cmd_reg <= front_cmd_next;
        end
    end

endmodule

// File: src/i2cps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cps_queue
// small request queue between the front and the sequencer
// ----------------------------------------------------------------------------
module i2cps_queue #(
    parameter int DEPTH = i2cps_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  i2cps_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  logic            pop,
    output i2cps_pkg::cmd_t pop_cmd
);
    import i2cps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/i2cps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cps_back
// runs each request as a series of line phases, one phase per cycle unless m_ready holds it
// ----------------------------------------------------------------------------
module i2cps_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  i2cps_pkg::cmd_t                q_cmd,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_scl_level,
    output logic                           m_sda_level,
    output logic                           m_sda_release,
    output logic [i2cps_pkg::DATA_W-1:0]   m_read_byte,
    output logic                           m_last_phase
);
    import i2cps_pkg::*;

    logic                busy_reg;
    logic [OP_W-1:0]     op_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [1:0]          sub_reg;
    logic                scl_reg;
    logic                sda_reg;
    logic                rel_reg;
    logic [DATA_W-1:0]   byte_reg;
    logic                last_reg;
    logic                valid_reg;

    logic [OP_W-1:0]     op_cur;
    logic [DATA_W-1:0]   data_cur;
    logic                emit;
    logic                scl_next;
    logic                sda_next;
    logic                rel_next;
    logic [DATA_W-1:0]   byte_next;
    logic                last_next;
    logic [DATA_W-1:0]   data_next;
    logic [1:0]          sub_next;

    assign op_cur   = busy_reg ? op_reg : q_cmd.op;
    assign data_cur = busy_reg ? data_reg : q_cmd.data;
    assign emit     = (busy_reg || q_valid) && (!valid_reg || m_ready);
    assign q_pop    = emit && !busy_reg;

    always_comb begin
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        rel_next  = rel_reg;
        byte_next = '0;
        last_next = 1'b0;
        data_next = data_cur;
        sub_next  = 2'd0;
        unique case (op_cur)
            OP_START: begin
                case (phase_reg)
                    5'd0:    sda_next = 1'b1;
                    5'd1:    scl_next = 1'b1;
                    5'd2:    sda_next = 1'b0;
                    default: begin
                        scl_next  = 1'b0;
                        last_next = 1'b1;
                    end
                endcase
            end
            OP_STOP: begin
                case (phase_reg)
                    5'd0:    sda_next = 1'b0;
                    5'd1:    scl_next = 1'b1;
                    default: begin
                        sda_next  = 1'b1;
                        last_next = 1'b1;
                    end
                endcase
            end
            OP_WRITE: begin
                if (phase_reg == WR_LAST_PHASE) begin
                    sda_next  = 1'b1;
                    last_next = 1'b1;
                end else if (phase_reg == WR_CLK_LOW_PHASE) begin
                    scl_next = 1'b0;
                end else begin
                    sub_next = (sub_reg == SUB_CLK_HIGH) ? SUB_CLK_LOW : sub_reg + 1'b1;
                    case (sub_reg)
                        SUB_CLK_LOW: scl_next = 1'b0;
                        SUB_DATA:    sda_next = data_cur[DATA_W-1];
                        default: begin
                            scl_next  = 1'b1;
                            data_next = {data_cur[DATA_W-2:0], 1'b0};
                        end
                    endcase
                end
            end
            OP_READ: begin
                if (phase_reg == 5'd0) begin
                    scl_next = 1'b0;
                end else if (phase_reg == 5'd1) begin
                    sda_next = 1'b1;
                    rel_next = 1'b1;
                end else if (phase_reg == RD_LAST_PHASE) begin
                    rel_next  = 1'b0;
                    last_next = 1'b1;
                    byte_next = data_cur;
                end else begin
                    scl_next = ~phase_reg[0];
                end
            end
            OP_WAIT: begin
                case (phase_reg)
                    5'd0:    rel_next = 1'b1;
                    5'd1:    scl_next = 1'b1;
                    5'd2:    scl_next = 1'b0;
                    default: begin
                        rel_next  = 1'b0;
                        last_next = 1'b1;
                    end
                endcase
            end
            default: begin
                last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            sub_reg   <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                busy_reg  <= !last_next;
                phase_reg <= last_next ? '0 : phase_reg + 1'b1;
                sub_reg   <= last_next ? '0 : sub_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                rel_reg   <= rel_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            op_reg   <= op_cur;
            data_reg <= data_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_scl_level   = scl_reg;
    assign m_sda_level   = sda_reg;
    assign m_sda_release = rel_reg;
    assign m_read_byte   = byte_reg;
    assign m_last_phase  = last_reg;

endmodule

// File: src/i2c_master_phase_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_phase_sequencer
// turns i2c master requests into runs of scl / sda pin phases
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_operation s_write_data s_line_bits
//  m_      | out       | m_valid m_ready m_scl_level m_sda_level m_sda_release
//          |           | m_read_byte m_last_phase
//
//  one phase per cycle from the sequencer phase counter unless m_ready holds it;
//  each run ends on the phase flagged by m_last_phase; unknown operations give none
//  runs follow each other with no gap; requests queue up behind the one running
//  reset leaves scl high, sda high and driven, with no request pending
//  m_ready low holds the sequencer on its current phase
// ----------------------------------------------------------------------------
module i2c_master_phase_sequencer #(
    parameter int QUEUE_DEPTH = i2cps_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [i2cps_pkg::OP_W-1:0]     s_operation,
    input  logic [i2cps_pkg::DATA_W-1:0]   s_write_data,
    input  logic [i2cps_pkg::DATA_W-1:0]   s_line_bits,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_scl_level,
    output logic                           m_sda_level,
    output logic                           m_sda_release,
    output logic [i2cps_pkg::DATA_W-1:0]   m_read_byte,
    output logic                           m_last_phase
);
    import i2cps_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    i2cps_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_write_data (s_write_data),
        .s_line_bits  (s_line_bits),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    i2cps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    i2cps_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_level   (m_scl_level),
        .m_sda_level   (m_sda_level),
        .m_sda_release (m_sda_release),
        .m_read_byte   (m_read_byte),
        .m_last_phase  (m_last_phase)
    );

`ifndef SYNTHESIS
    a_byte_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_phase) |-> (m_read_byte == '0))
        else $error("read byte shown before the last phase");

    a_byte_with_sda_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_byte != '0)) |-> !m_sda_release)
        else $error("read byte shown while sda still released");
`endif

endmodule
